[design/pidff_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidff_pkg
// Shared types and fixed widths for the PID controller with feedforward.
// ----------------------------------------------------------------------------
package pidff_pkg;

   localparam int GAIN_W      = 16;   // Q8.8 gains
   localparam int LIMIT_W     = 15;   // clamp magnitudes
   localparam int INTEG_W     = 16;   // stored integral
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;   // widest register

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROP_GAIN       = 3'd0,
      CSR_INTEG_GAIN      = 3'd1,
      CSR_DERIV_GAIN      = 3'd2,
      CSR_FF_STATIC_GAIN  = 3'd3,
      CSR_FF_DYNAMIC_GAIN = 3'd4,
      CSR_INTEG_LIMIT     = 3'd5,
      CSR_OUTPUT_LIMIT    = 3'd6
   } csr_index_type;

   localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST       = 16'sd256;
   localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST      = 16'sd1;
   localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST      = 16'sd26;
   localparam logic signed [GAIN_W-1:0] FF_STATIC_GAIN_RST  = 16'sd0;
   localparam logic signed [GAIN_W-1:0] FF_DYNAMIC_GAIN_RST = 16'sd0;
   localparam logic [LIMIT_W-1:0]       INTEG_LIMIT_RST     = 15'd205;
   localparam logic [LIMIT_W-1:0]       OUTPUT_LIMIT_RST    = 15'd4096;

   typedef struct packed {
      logic signed [GAIN_W-1:0] prop_gain;
      logic signed [GAIN_W-1:0] integ_gain;
      logic signed [GAIN_W-1:0] deriv_gain;
      logic signed [GAIN_W-1:0] ff_static_gain;
      logic signed [GAIN_W-1:0] ff_dynamic_gain;
      logic [LIMIT_W-1:0]       integ_limit;
      logic [LIMIT_W-1:0]       output_limit;
   } gains_type;

endpackage
`default_nettype wire

[design/pidff_csr.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidff_csr
// Gain and limit registers, written through a plain write port.
// ----------------------------------------------------------------------------
module pidff_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_enable,
   input  wire logic [pidff_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [pidff_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output pidff_pkg::gains_type                       gains
);

   pidff_pkg::gains_type gains_ff;
   pidff_pkg::gains_type gains_in;

   always_comb begin
      gains_in = gains_ff;
      if (csr_write_enable) begin
         case (pidff_pkg::csr_index_type'(csr_index))
            pidff_pkg::CSR_PROP_GAIN:
               gains_in.prop_gain = $signed(csr_write_data);
            pidff_pkg::CSR_INTEG_GAIN:
               gains_in.integ_gain = $signed(csr_write_data);
            pidff_pkg::CSR_DERIV_GAIN:
               gains_in.deriv_gain = $signed(csr_write_data);
            pidff_pkg::CSR_FF_STATIC_GAIN:
               gains_in.ff_static_gain = $signed(csr_write_data);
            pidff_pkg::CSR_FF_DYNAMIC_GAIN:
               gains_in.ff_dynamic_gain = $signed(csr_write_data);
            pidff_pkg::CSR_INTEG_LIMIT:
               gains_in.integ_limit = csr_write_data[pidff_pkg::LIMIT_W-1:0];
            pidff_pkg::CSR_OUTPUT_LIMIT:
               gains_in.output_limit = csr_write_data[pidff_pkg::LIMIT_W-1:0];
            default: ; // unused index: write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.prop_gain       <= pidff_pkg::PROP_GAIN_RST;
         gains_ff.integ_gain      <= pidff_pkg::INTEG_GAIN_RST;
         gains_ff.deriv_gain      <= pidff_pkg::DERIV_GAIN_RST;
         gains_ff.ff_static_gain  <= pidff_pkg::FF_STATIC_GAIN_RST;
         gains_ff.ff_dynamic_gain <= pidff_pkg::FF_DYNAMIC_GAIN_RST;
         gains_ff.integ_limit     <= pidff_pkg::INTEG_LIMIT_RST;
         gains_ff.output_limit    <= pidff_pkg::OUTPUT_LIMIT_RST;
      end else begin
         gains_ff <= gains_in;
      end
   end

   assign gains = gains_ff;

endmodule
`default_nettype wire

[design/pidff_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidff_datapath
// Error, five gain products, integral update and output clamp for one sample;
// holds the previous error and the integral.
// ----------------------------------------------------------------------------
module pidff_datapath #(
   parameter int DATA_WIDTH     = 16,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pidff_pkg::gains_type          gains,
   input  wire logic                          step,
   input  wire logic signed [DATA_WIDTH-1:0]  reference,
   input  wire logic signed [DATA_WIDTH-1:0]  feedback,
   output logic signed [DATA_WIDTH-1:0]       drive
);

   localparam int ERR_W     = DATA_WIDTH + 1;
   localparam int DIFF_W    = DATA_WIDTH + 2;
   localparam int PROD_W    = pidff_pkg::GAIN_W + DIFF_W;
   localparam int ISUM_W    = PROD_W + 1;
   localparam int SUM_W     = PROD_W + 3;
   localparam int INTEG_W   = pidff_pkg::INTEG_W;

   logic signed [ERR_W-1:0]   prev_error_ff;
   logic signed [ERR_W-1:0]   prev_error_in;
   logic signed [INTEG_W-1:0] integral_ff;
   logic signed [INTEG_W-1:0] integral_in;

   logic signed [ERR_W-1:0]   err;
   logic signed [DIFF_W-1:0]  err_diff;
   logic signed [PROD_W-1:0]  p_term, i_step, d_term, ffs_term, ffd_term;
   logic signed [ISUM_W-1:0]  integ_sum, integ_lim, integ_clamped;
   logic signed [SUM_W-1:0]   total, out_lim, total_clamped;

   // products exact, then floor shift each on its own
   always_comb begin
      err      = ERR_W'(reference) - ERR_W'(feedback);
      err_diff = DIFF_W'(err) - DIFF_W'(prev_error_ff);
      p_term   = (PROD_W'(gains.prop_gain) * PROD_W'(err)) >>> GAIN_FRAC_BITS;
      i_step   = (PROD_W'(gains.integ_gain) * PROD_W'(err)) >>> GAIN_FRAC_BITS;
      d_term   = (PROD_W'(gains.deriv_gain) * PROD_W'(err_diff)) >>> GAIN_FRAC_BITS;
      ffs_term = (PROD_W'(gains.ff_static_gain) * PROD_W'(reference)) >>> GAIN_FRAC_BITS;
      ffd_term = (PROD_W'(gains.ff_dynamic_gain) * PROD_W'(err)) >>> GAIN_FRAC_BITS;
   end

   // integral clamp to +/- integ_limit
   always_comb begin
      integ_sum = ISUM_W'(integral_ff) + ISUM_W'(i_step);
      integ_lim = ISUM_W'($signed({1'b0, gains.integ_limit}));
      if (integ_sum > integ_lim) begin
         integ_clamped = integ_lim;
      end else if (integ_sum < -integ_lim) begin
         integ_clamped = -integ_lim;
      end else begin
         integ_clamped = integ_sum;
      end
   end

   // full-width sum, then output saturation
   always_comb begin
      total = SUM_W'(p_term) + SUM_W'(integ_clamped) + SUM_W'(d_term)
            + SUM_W'(ffs_term) + SUM_W'(ffd_term);
      out_lim = SUM_W'($signed({1'b0, gains.output_limit}));
      if (total > out_lim) begin
         total_clamped = out_lim;
      end else if (total < -out_lim) begin
         total_clamped = -out_lim;
      end else begin
         total_clamped = total;
      end
   end

   assign drive = total_clamped[DATA_WIDTH-1:0];

   always_comb begin
      prev_error_in = prev_error_ff;
      integral_in   = integral_ff;
      if (step) begin
         prev_error_in = err;
         integral_in   = integ_clamped[INTEG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff <= '0;
         integral_ff   <= '0;
      end else begin
         prev_error_ff <= prev_error_in;
         integral_ff   <= integral_in;
      end
   end

endmodule
`default_nettype wire

[design/pid_feedforward_controller_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pid_feedforward_controller_core
// PID controller with feedforward: one saturated drive value per sample.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  req_      in         req_valid / req_ready     req_reference, req_feedback
//  rsp_      out        rsp_valid / rsp_ready     rsp_drive
//  csr_      in         csr_write_enable          csr_index, csr_write_data
//
//  One sample per cycle sustained while rsp_ready stays high; a req transfer
//  passes the input register, then the result register, which raises rsp_valid.
//  The products, integral update and clamps sit in one combinational pass
//  between the input register and the result register.
//  Synchronous active-high reset clears valids, integral and previous error,
//  and restores the register defaults.
//  A stalled rsp_ held in the result register still lets the input register
//  fill, so one further sample is taken before req_ready drops.
// ----------------------------------------------------------------------------
module pid_feedforward_controller_core #(
   parameter int DATA_WIDTH     = 16,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // sample input
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [DATA_WIDTH-1:0]          req_reference,
   input  wire logic signed [DATA_WIDTH-1:0]          req_feedback,
   // result output
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [DATA_WIDTH-1:0]               rsp_drive,
   // register writes
   input  wire logic                                  csr_write_enable,
   input  wire logic [pidff_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [pidff_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   pidff_pkg::gains_type gains;

   // input register
   logic                          in_valid_ff, in_valid_in;
   logic signed [DATA_WIDTH-1:0]  reference_ff, reference_in;
   logic signed [DATA_WIDTH-1:0]  feedback_ff, feedback_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0]  rsp_drive_ff, rsp_drive_in;

   logic                          out_free;   // result register can load
   logic                          step;       // input register moves on
   logic                          req_xfer;
   logic signed [DATA_WIDTH-1:0]  drive_calc;

   pidff_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .gains            (gains)
   );

   pidff_datapath #(
      .DATA_WIDTH     (DATA_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .gains     (gains),
      .step      (step),
      .reference (reference_ff),
      .feedback  (feedback_ff),
      .drive     (drive_calc)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      reference_in = reference_ff;
      feedback_in  = feedback_ff;
      if (req_ready) begin
         in_valid_in  = req_valid;
      end
      if (req_xfer) begin
         reference_in = req_reference;
         feedback_in  = req_feedback;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_drive_in = rsp_drive_ff;
      if (out_free) begin
         rsp_valid_in = in_valid_ff;
      end
      if (step) begin
         rsp_drive_in = drive_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      reference_ff <= reference_in;
      feedback_ff  <= feedback_in;
      rsp_drive_ff <= rsp_drive_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

endmodule
`default_nettype wire

[design/pidff_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidff_checker
// Port-level checks on the controller's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module pidff_checker #(
   parameter int DATA_WIDTH = 16
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [DATA_WIDTH-1:0]  rsp_drive
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive))
      else $error("rsp_ dropped or changed while stalled");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set straight after reset");

   // a free output side never blocks the input side
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("req_ready low with output side free");

   // after a taken sample, rsp_valid is high once the input and result registers are passed
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("no result two cycles after req transfer");

endmodule

bind pid_feedforward_controller_core pidff_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_pidff_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_drive (rsp_drive)
);
`default_nettype wire

[verif/pid_feedforward_controller_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_feedforward_controller_checker
// Watches the sample, drive and register ports of the PID core, predicts
// each drive value from its own copy of the gains and loop state, and
// compares the drive transfers in order against the predictions.
// ----------------------------------------------------------------------------
module pid_feedforward_controller_checker #(
   parameter int DATA_WIDTH     = 16,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   input  wire logic                                  req_ready,
   input  wire logic signed [DATA_WIDTH-1:0]          req_reference,
   input  wire logic signed [DATA_WIDTH-1:0]          req_feedback,
   input  wire logic                                  rsp_valid,
   input  wire logic                                  rsp_ready,
   input  wire logic signed [DATA_WIDTH-1:0]          rsp_drive,
   input  wire logic                                  csr_write_enable,
   input  wire logic [pidff_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [pidff_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output int                                         fail_count,
   output int                                         pending
);

   localparam int PRINT_LIMIT = 100;

   typedef logic signed [DATA_WIDTH-1:0] sample_type;
   typedef logic signed [pidff_pkg::INTEG_W-1:0] integ_type;

   pidff_pkg::gains_type         gains;
   logic signed [DATA_WIDTH:0]   last_error;
   integ_type                    integ_acc;
   sample_type                   drive_expected_q[$];
   int                           failures = 0;
   int                           drive_count = 0;

   task automatic report_mismatch(input string msg);
      if (failures < PRINT_LIMIT) begin
         $display("[%0t] drive %0d: %s", $time, drive_count, msg);
      end
      failures = failures + 1;
   endtask

   // arithmetic shift of a full-width product, rounds towards minus infinity
   function automatic longint floor_shift(input longint v);
      return v >>> GAIN_FRAC_BITS;
   endfunction

   function automatic longint clamp_sym(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // one control step: updates integral and previous error, returns drive
   function automatic sample_type predict_drive(input sample_type reference,
                                                input sample_type feedback);
      longint error, p_term, d_term, ff_term, total;
      error   = longint'(reference) - longint'(feedback);
      p_term  = floor_shift(longint'($signed(gains.prop_gain)) * error);
      integ_acc = integ_type'(clamp_sym(longint'(integ_acc)
                     + floor_shift(longint'($signed(gains.integ_gain)) * error),
                     longint'(gains.integ_limit)));
      d_term  = floor_shift(longint'($signed(gains.deriv_gain))
                            * (error - longint'(last_error)));
      ff_term = floor_shift(longint'($signed(gains.ff_static_gain)) * longint'(reference))
              + floor_shift(longint'($signed(gains.ff_dynamic_gain)) * error);
      total   = clamp_sym(p_term + longint'(integ_acc) + d_term + ff_term,
                          longint'(gains.output_limit));
      last_error = (DATA_WIDTH+1)'(error);
      return sample_type'(total);
   endfunction

   always @(posedge clock) begin
      sample_type expected;
      if (reset) begin
         gains = '{prop_gain:       pidff_pkg::PROP_GAIN_RST,
                   integ_gain:      pidff_pkg::INTEG_GAIN_RST,
                   deriv_gain:      pidff_pkg::DERIV_GAIN_RST,
                   ff_static_gain:  pidff_pkg::FF_STATIC_GAIN_RST,
                   ff_dynamic_gain: pidff_pkg::FF_DYNAMIC_GAIN_RST,
                   integ_limit:     pidff_pkg::INTEG_LIMIT_RST,
                   output_limit:    pidff_pkg::OUTPUT_LIMIT_RST};
         last_error = '0;
         integ_acc  = '0;
         drive_expected_q.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               pidff_pkg::CSR_PROP_GAIN:
                  gains.prop_gain       = csr_write_data;
               pidff_pkg::CSR_INTEG_GAIN:
                  gains.integ_gain      = csr_write_data;
               pidff_pkg::CSR_DERIV_GAIN:
                  gains.deriv_gain      = csr_write_data;
               pidff_pkg::CSR_FF_STATIC_GAIN:
                  gains.ff_static_gain  = csr_write_data;
               pidff_pkg::CSR_FF_DYNAMIC_GAIN:
                  gains.ff_dynamic_gain = csr_write_data;
               pidff_pkg::CSR_INTEG_LIMIT:
                  gains.integ_limit     = csr_write_data[pidff_pkg::LIMIT_W-1:0];
               pidff_pkg::CSR_OUTPUT_LIMIT:
                  gains.output_limit    = csr_write_data[pidff_pkg::LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            drive_expected_q.insert(drive_expected_q.size(),
                                    predict_drive(req_reference, req_feedback));
         end
         if (rsp_valid && rsp_ready) begin
            if (drive_expected_q.size() == 0) begin
               report_mismatch($sformatf("drive %0d with nothing expected", rsp_drive));
            end else begin
               expected = drive_expected_q.pop_front();
               if (rsp_drive !== expected) begin
                  report_mismatch($sformatf("expected %0d, got %0d", expected, rsp_drive));
               end
            end
            drive_count = drive_count + 1;
         end
      end
      pending    <= drive_expected_q.size();
      fail_count <= failures;
   end

endmodule

[verif/pid_feedforward_controller_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_feedforward_controller_core_test
// Drives samples and register writes into the PID core with feedforward,
// stalls both channels at random and twice for a long stretch, and leaves
// prediction and comparison to the checker beside the core.
// ----------------------------------------------------------------------------
module pid_feedforward_controller_core_test;

   localparam int DATA_WIDTH       = 16;
   localparam int GAIN_FRAC_BITS   = 8;
   localparam int PHASES           = 12;    // phase 0 runs on reset defaults
   localparam int RANDOM_PER_PHASE = 100;
   localparam int HOLD_OFF_CYCLES  = 300;   // long receiver stall
   localparam int SETTLE_CYCLES    = 6;     // idle pause after the last drive
   localparam int WATCHDOG_LIMIT   = 2000;  // cycles without any transfer

   typedef logic signed [DATA_WIDTH-1:0] sample_type;
   typedef logic [pidff_pkg::CSR_DATA_W-1:0] csr_data_type;
   typedef logic [pidff_pkg::CSR_INDEX_W-1:0] csr_addr_type;

   // the register map stops at index 6, so 7 must be ignored by the core
   localparam csr_addr_type CSR_INDEX_UNUSED = 3'd7;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   sample_type              req_reference = '0;
   sample_type              req_feedback = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   sample_type              rsp_drive;
   logic                    csr_write_enable = 1'b0;
   csr_addr_type            csr_index = '0;
   csr_data_type            csr_write_data = '0;

   int                      fail_count;
   int                      pending;
   int                      idle_cycles = 0;
   bit                      no_gaps = 1'b0;        // back-to-back stretch on both sides
   int                      holds_asked = 0;       // long receiver stalls asked for
   int                      track_ref = 0;         // slowly moving reference

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pid_feedforward_controller_core #(
      .DATA_WIDTH     (DATA_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_reference    (req_reference),
      .req_feedback     (req_feedback),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_drive        (rsp_drive),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   pid_feedforward_controller_checker #(
      .DATA_WIDTH     (DATA_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_reference    (req_reference),
      .req_feedback     (req_feedback),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_drive        (rsp_drive),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   // Watchdog: any transfer on either channel restarts the count. The long
   // receiver stall and the settle pauses stay well inside the limit.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Per-item wait; about half the items go without a gap, and all do while no_gaps is set.
   function automatic int unsigned draw_gap();
      if (no_gaps) return 0;
      if ($urandom_range(0, 1) == 0) return 0;
      return $urandom_range(1, 16);
   endfunction

   function automatic sample_type clip_sample(input int v);
      if (v > 32767) return sample_type'(32767);
      if (v < -32768) return sample_type'(-32768);
      return sample_type'(v);
   endfunction

   // Gains: a third anywhere in range, the rest between -2.0 and +2.0 (Q8.8) so that the
   // output is not always pinned at the limit.
   function automatic csr_data_type draw_gain();
      int g;
      if ($urandom_range(0, 2) == 0) return csr_data_type'($urandom);
      g = $urandom_range(0, 1024);
      return csr_data_type'(g - 512);
   endfunction

   // Receiver: stalls a drawn number of cycles before each result, then
   // holds ready until the transfer. An outstanding hold request replaces
   // the draw with one long stall so the core backs up into req_ready.
   initial begin : receiver
      int unsigned stall;
      int holds_done;
      holds_done = 0;
      wait (!reset);
      @(posedge clock);
      forever begin
         stall = draw_gap();
         if (holds_done != holds_asked) begin
            stall = HOLD_OFF_CYCLES;
            holds_done = holds_done + 1;
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // One sample transfer. Valid stays high into the next call when that
   // call has no gap, so the next sample follows back to back.
   task automatic send_sample(input sample_type reference, input sample_type feedback);
      int unsigned gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_reference <= reference;
      req_feedback  <= feedback;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // Random sample: full-range noise, a tracking loop with small errors, or
   // a random level with a tiny error around it.
   task automatic send_random();
      int choice, step, offset;
      sample_type reference;
      choice = $urandom_range(0, 9);
      if (choice < 4) begin
         send_sample(sample_type'($urandom), sample_type'($urandom));
      end else if (choice < 8) begin
         step      = $urandom_range(0, 512);
         offset    = $urandom_range(0, 128);
         track_ref = int'(clip_sample(track_ref + step - 256));
         send_sample(sample_type'(track_ref), clip_sample(track_ref + offset - 64));
      end else begin
         offset    = $urandom_range(0, 16);
         reference = sample_type'($urandom);
         send_sample(reference, clip_sample(int'(reference) + offset - 8));
      end
   endtask

   // Stop offering, wait until every expected drive has arrived, then let
   // the pipeline settle. Called at the step of the last sample transfer.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Enable is left high between back-to-back writes and lowered once the
   // batch is done.
   task automatic write_register(input csr_addr_type index,
                                 input csr_data_type value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   // Limits are passed at full port width: bit 15 must be dropped.
   task automatic program_gains(input csr_data_type prop, integ, deriv,
                                input csr_data_type ff_static, ff_dynamic,
                                input csr_data_type integ_lim, out_lim);
      write_register(pidff_pkg::CSR_PROP_GAIN,       prop);
      write_register(pidff_pkg::CSR_INTEG_GAIN,      integ);
      write_register(pidff_pkg::CSR_DERIV_GAIN,      deriv);
      write_register(pidff_pkg::CSR_FF_STATIC_GAIN,  ff_static);
      write_register(pidff_pkg::CSR_FF_DYNAMIC_GAIN, ff_dynamic);
      write_register(pidff_pkg::CSR_INTEG_LIMIT,     integ_lim);
      write_register(pidff_pkg::CSR_OUTPUT_LIMIT,    out_lim);
      write_register(CSR_INDEX_UNUSED,               csr_data_type'($urandom));
      csr_write_enable <= 1'b0;
   endtask

   initial begin : stimulus
      int phase;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: extremes of both fields, the integral driven into
      // its clamp both ways, and the largest error swings for the
      // derivative term.
      send_sample(16'sd0, 16'sd0);
      send_sample(16'sh7fff, 16'sh8000);
      send_sample(16'sh7fff, 16'sh8000);
      send_sample(16'sh7fff, 16'sh8000);
      send_sample(16'sh8000, 16'sh7fff);
      send_sample(16'sh8000, 16'sh7fff);
      send_sample(16'sh8000, 16'sh7fff);
      send_sample(16'sh7fff, 16'sh8000);
      send_sample(16'sh7fff, 16'sh7fff);
      send_sample(16'sh8000, 16'sh8000);
      send_sample(16'sh8000, 16'sd0);
      send_sample(16'sd0, 16'sh8000);
      send_sample(16'sd1, 16'sd0);
      send_sample(-16'sd1, 16'sd0);
      send_sample(16'sd0, 16'sd1);
      send_sample(16'sd4096, 16'sd4000);
      send_sample(-16'sd4096, -16'sd4000);
      send_sample(16'sd0, -16'sd1);
      repeat (RANDOM_PER_PHASE) send_random();

      for (phase = 1; phase < PHASES; phase++) begin
         settle();
         no_gaps = (phase % 3 == 2);
         case (phase)
            // largest gains everywhere; limits written as 16'hffff
            1: program_gains(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                             16'hffff, 16'hffff);
            // most negative gains; integral limit written as bit 15 only,
            // which leaves zero
            2: program_gains(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                             16'h8000, 16'h7fff);
            // both limits zero: integral pinned and drive forced to zero
            3: program_gains(draw_gain(), draw_gain(), draw_gain(), draw_gain(),
                             draw_gain(), 16'h0000, 16'h0000);
            // integral limit zero, output wide open
            4: program_gains(draw_gain(), draw_gain(), draw_gain(), draw_gain(),
                             draw_gain(), 16'h0000, 16'h7fff);
            // unity proportional and feedforward, wide limits
            5: program_gains(16'h0100, 16'h0010, 16'h0000, 16'h0100, 16'h0100,
                             16'h7fff, 16'h7fff);
            default: program_gains(draw_gain(), draw_gain(), draw_gain(), draw_gain(),
                                   draw_gain(), csr_data_type'($urandom),
                                   csr_data_type'($urandom));
         endcase

         // the long receiver stall lands in two of the no-gap phases so the
         // sender keeps offering and the core fills up
         if (phase == 5 || phase == 8) begin
            holds_asked = holds_asked + 1;
         end

         // field extremes under each new setting
         send_sample(16'sh7fff, 16'sh8000);
         send_sample(16'sh8000, 16'sh7fff);
         send_sample(16'sh7fff, 16'sd0);
         send_sample(16'sh8000, 16'sd0);
         repeat (RANDOM_PER_PHASE) send_random();
      end

      settle();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
